>>> design/cdd_pkg.sv
// Package for the calendar day difference block: sequencer states, control word,
// shared multiplier operation codes, field widths and the month offset table.
// No dependencies.
package cdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OUT_W   = 23;
  localparam int ACC_W   = 25;
  localparam int PROD_W  = 27;
  localparam int QUOT_LSB = 17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_C100,
    ST_C400,
    ST_F100,
    ST_QTR,
    ST_MD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MOP_YEAR,
    MOP_C100,
    MOP_C400,
    MOP_F100
  } mop_t;

  typedef enum logic [2:0] {
    AOP_NONE,
    AOP_PROD,
    AOP_QUOT,
    AOP_QTR,
    AOP_MD
  } aop_t;

  typedef struct packed {
    mop_t mop;
    aop_t aop;
    logic sub;
    logic second;
    logic leap_load;
    logic acc_clr;
    logic done;
  } ctrl_t;

  // Days in the months before the given month of a common year. Month zero
  // counts as January and months above twelve count as December.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
    logic [8:0] days;
    case (month)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      default: days = 9'd334;
    endcase
    return days;
  endfunction

endpackage

>>> design/cdd_mul.sv
// Shared constant multiplier of the calendar day difference block. It forms the
// operand from the selected year and registers the product.
// Depends on cdd_pkg.
module cdd_mul (
  input  logic                        clk,
  input  cdd_pkg::mop_t               mop,
  input  logic [cdd_pkg::YEAR_W-1:0]  year,
  output logic [cdd_pkg::PROD_W-1:0]  prod
);

  localparam logic [12:0] DAYS_PER_YEAR = 13'd365;
  localparam logic [12:0] RECIP25       = 13'd5243;

  logic [14:0] year_p99;
  logic [14:0] year_p399;
  logic [13:0] opnd;
  logic [12:0] cst;

  assign year_p99  = {1'b0, year} + 15'd99;
  assign year_p399 = {1'b0, year} + 15'd399;

  always_comb begin
    case (mop)
      cdd_pkg::MOP_YEAR: begin
        opnd = year;
        cst  = DAYS_PER_YEAR;
      end
      cdd_pkg::MOP_C100: begin
        opnd = {1'b0, year_p99[14:2]};
        cst  = RECIP25;
      end
      cdd_pkg::MOP_C400: begin
        opnd = {3'b0, year_p399[14:4]};
        cst  = RECIP25;
      end
      cdd_pkg::MOP_F100: begin
        opnd = {2'b0, year[13:2]};
        cst  = RECIP25;
      end
      default: begin
        opnd = year;
        cst  = DAYS_PER_YEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {13'd0, opnd} * {14'd0, cst};
  end

endmodule

>>> design/cdd_ctrl.sv
// Sequencer of the calendar day difference block. It steps the shared multiplier
// and the accumulator through both dates of a word.
// Depends on cdd_pkg.
module cdd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           out_free,
  output logic           idle,
  output cdd_pkg::ctrl_t ctrl
);

  cdd_pkg::state_t state;
  cdd_pkg::state_t state_next;
  logic            second;
  logic            second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= cdd_pkg::ST_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next  = state;
    second_next = second;
    case (state)
      cdd_pkg::ST_IDLE: begin
        second_next = 1'b0;
        if (start) begin
          state_next = cdd_pkg::ST_YEAR;
        end
      end
      cdd_pkg::ST_YEAR: state_next = cdd_pkg::ST_C100;
      cdd_pkg::ST_C100: state_next = cdd_pkg::ST_C400;
      cdd_pkg::ST_C400: state_next = cdd_pkg::ST_F100;
      cdd_pkg::ST_F100: state_next = cdd_pkg::ST_QTR;
      cdd_pkg::ST_QTR:  state_next = cdd_pkg::ST_MD;
      cdd_pkg::ST_MD: begin
        if (second) begin
          state_next = cdd_pkg::ST_DONE;
        end else begin
          second_next = 1'b1;
          state_next  = cdd_pkg::ST_YEAR;
        end
      end
      cdd_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = cdd_pkg::ST_IDLE;
        end
      end
      default: state_next = cdd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    ctrl.mop       = cdd_pkg::MOP_YEAR;
    ctrl.aop       = cdd_pkg::AOP_NONE;
    ctrl.second    = second;
    idle           = 1'b0;
    case (state)
      cdd_pkg::ST_IDLE: begin
        idle         = 1'b1;
        ctrl.acc_clr = 1'b1;
      end
      cdd_pkg::ST_YEAR: begin
        ctrl.mop = cdd_pkg::MOP_YEAR;
      end
      cdd_pkg::ST_C100: begin
        ctrl.mop = cdd_pkg::MOP_C100;
        ctrl.aop = cdd_pkg::AOP_PROD;
        ctrl.sub = second;
      end
      cdd_pkg::ST_C400: begin
        ctrl.mop = cdd_pkg::MOP_C400;
        ctrl.aop = cdd_pkg::AOP_QUOT;
        ctrl.sub = !second;
      end
      cdd_pkg::ST_F100: begin
        ctrl.mop = cdd_pkg::MOP_F100;
        ctrl.aop = cdd_pkg::AOP_QUOT;
        ctrl.sub = second;
      end
      cdd_pkg::ST_QTR: begin
        ctrl.aop       = cdd_pkg::AOP_QTR;
        ctrl.sub       = second;
        ctrl.leap_load = 1'b1;
      end
      cdd_pkg::ST_MD: begin
        ctrl.aop = cdd_pkg::AOP_MD;
        ctrl.sub = second;
      end
      cdd_pkg::ST_DONE: begin
        ctrl.done = out_free;
      end
      default: begin
        ctrl.acc_clr = 1'b1;
      end
    endcase
  end

endmodule

>>> design/calendar_day_difference.sv
// Top level of the calendar day difference block: input capture, accumulator,
// leap year test, saturation and output register.
// Depends on cdd_pkg, cdd_mul and cdd_ctrl.
//
// The block takes a word of two Gregorian dates on the input channel and returns
// the signed day count first minus second on the output channel.
// Both channels use valid and ready; a word moves when both are high at a
// rising edge of clk.
// Each date is turned into a day count by one shared constant multiplier that
// is used four times per date (years times 365 and three divisions by 100 or
// 400 through a reciprocal), with an accumulator adding the terms.
// The input is not ready while a word is in work: a new word is accepted only once
// the sequencer has passed the last result to the output register and is idle again.
// A finished result waits in the output register while the next word is taken.
// If the receiver stalls, the sequencer holds its last step until the output
// register is free, and the input stays not ready meanwhile.
// Synchronous reset returns the sequencer to idle and drops out_valid.
// Results beyond the 23-bit range saturate.
module calendar_day_difference (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cdd_pkg::YEAR_W-1:0]         first_year,
  input  logic [cdd_pkg::MONTH_W-1:0]        first_month,
  input  logic [cdd_pkg::DAY_W-1:0]          first_day,
  input  logic [cdd_pkg::YEAR_W-1:0]         second_year,
  input  logic [cdd_pkg::MONTH_W-1:0]        second_month,
  input  logic [cdd_pkg::DAY_W-1:0]          second_day,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cdd_pkg::OUT_W-1:0]   day_difference
);

  localparam logic signed [24:0] OUT_MAX   = 25'sd4194303;
  localparam logic signed [24:0] OUT_MIN   = -25'sd4194304;
  localparam logic signed [24:0] ACC_BOUND = 25'sd6100000;

  cdd_pkg::ctrl_t ctrl;
  logic           start;
  logic           out_free;

  logic [cdd_pkg::YEAR_W-1:0]  y1;
  logic [cdd_pkg::MONTH_W-1:0] m1;
  logic [cdd_pkg::DAY_W-1:0]   d1;
  logic [cdd_pkg::YEAR_W-1:0]  y2;
  logic [cdd_pkg::MONTH_W-1:0] m2;
  logic [cdd_pkg::DAY_W-1:0]   d2;

  logic [cdd_pkg::YEAR_W-1:0]  yr;
  logic [cdd_pkg::MONTH_W-1:0] mo;
  logic [cdd_pkg::DAY_W-1:0]   dy;

  logic [cdd_pkg::PROD_W-1:0]  prod;
  logic [9:0]                  quot;
  logic [14:0]                 quot_x25;
  logic [14:0]                 year_p3;
  logic [12:0]                 qtr;
  logic                        leap_now;
  logic                        leap;
  logic [9:0]                  md;
  logic [22:0]                 term;

  logic signed [cdd_pkg::ACC_W-1:0] acc;
  logic signed [cdd_pkg::ACC_W-1:0] acc_next;
  logic signed [cdd_pkg::OUT_W-1:0] sat;
  logic                             out_valid_next;

  assign start    = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  cdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .idle     (in_ready),
    .ctrl     (ctrl)
  );

  always_ff @(posedge clk) begin
    if (start) begin
      y1 <= first_year;
      m1 <= first_month;
      d1 <= first_day;
      y2 <= second_year;
      m2 <= second_month;
      d2 <= second_day;
    end
  end

  assign yr = ctrl.second ? y2 : y1;
  assign mo = ctrl.second ? m2 : m1;
  assign dy = ctrl.second ? d2 : d1;

  cdd_mul u_mul (
    .clk  (clk),
    .mop  (ctrl.mop),
    .year (yr),
    .prod (prod)
  );

  assign quot     = prod[cdd_pkg::PROD_W-1:cdd_pkg::QUOT_LSB];
  assign quot_x25 = {1'b0, quot, 4'b0} + {2'b0, quot, 3'b0} + {5'b0, quot};
  assign year_p3  = {1'b0, yr} + 15'd3;
  assign qtr      = year_p3[14:2];

  // While the quarter term is added, the product holds floor(year / 100).
  assign leap_now = (yr[1:0] == 2'd0) &&
                    (({3'b0, yr[13:2]} != quot_x25) || (yr[3:0] == 4'd0));

  always_ff @(posedge clk) begin
    if (ctrl.leap_load) begin
      leap <= leap_now;
    end
  end

  assign md = {1'b0, cdd_pkg::days_before_month(mo)} + {5'b0, dy} +
              {9'b0, (leap && (mo > 4'd2))};

  always_comb begin
    case (ctrl.aop)
      cdd_pkg::AOP_NONE: term = '0;
      cdd_pkg::AOP_PROD: term = prod[22:0];
      cdd_pkg::AOP_QUOT: term = {13'b0, quot};
      cdd_pkg::AOP_QTR:  term = {10'b0, qtr};
      cdd_pkg::AOP_MD:   term = {13'b0, md};
      default:           term = '0;
    endcase
  end

  always_comb begin
    if (ctrl.acc_clr) begin
      acc_next = '0;
    end else if (ctrl.sub) begin
      acc_next = acc - signed'({2'b0, term});
    end else begin
      acc_next = acc + signed'({2'b0, term});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  always_comb begin
    if (acc > OUT_MAX) begin
      sat = OUT_MAX[22:0];
    end else if (acc < OUT_MIN) begin
      sat = OUT_MIN[22:0];
    end else begin
      sat = acc[22:0];
    end
  end

  always_comb begin
    if (ctrl.done) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      day_difference <= sat;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("input ready right after an accepted word");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    ctrl.done |=> out_valid)
    else $error("finished result did not reach the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.done |-> (!out_valid || out_ready))
    else $error("result loaded while the previous one still waits");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    (acc <= ACC_BOUND) && (acc >= -ACC_BOUND))
    else $error("accumulator outside the range of two day counts");
`endif

endmodule

>>> sim/tb_calendar_day_difference.sv
// Testbench for calendar_day_difference: directed date pairs, then random ones under
// several idle and stall patterns, each checked against a typed or predicted count.
// Depends on cdd_pkg and the calendar_day_difference RTL.
module tb_calendar_day_difference;

  localparam int    CYCLE_LIMIT   = 200000;
  localparam int    TAIL_CYCLES   = 30;
  localparam int    LONG_HOLD     = 400;
  localparam int    PHASE_WORDS   = 105;
  localparam int    PRESSURE_WORDS = 30;
  localparam int    N_DIRECTED    = 20;
  localparam longint DIFF_MAX     = 4194303;
  localparam longint DIFF_MIN     = -4194304;

  typedef struct packed {
    logic [cdd_pkg::YEAR_W-1:0]  year;
    logic [cdd_pkg::MONTH_W-1:0] month;
    logic [cdd_pkg::DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t                             first;
    date_t                             second;
    logic                              typed;
    logic signed [cdd_pkg::OUT_W-1:0]  diff;
  } date_row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [cdd_pkg::YEAR_W-1:0]         first_year = '0;
  logic [cdd_pkg::MONTH_W-1:0]        first_month = '0;
  logic [cdd_pkg::DAY_W-1:0]          first_day = '0;
  logic [cdd_pkg::YEAR_W-1:0]         second_year = '0;
  logic [cdd_pkg::MONTH_W-1:0]        second_month = '0;
  logic [cdd_pkg::DAY_W-1:0]          second_day = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [cdd_pkg::OUT_W-1:0]   day_difference;

  logic signed [cdd_pkg::OUT_W-1:0]   pending_differences[$];
  logic signed [cdd_pkg::OUT_W-1:0]   expected_diff;
  int                        mismatch_count = 0;
  int                        cycle_count = 0;
  int                        send_idle_pct = 0;
  int                        recv_stall_pct = 0;
  int                        send_plan[4] = '{0, 83, 0, 19};
  int                        recv_plan[4] = '{0, 0, 83, 19};
  logic                      hold_trig = 1'b0;
  logic                      hold_seen = 1'b0;
  int                        hold_left = 0;
  date_t                     date_a;
  date_t                     date_b;

  date_row_t directed_rows [N_DIRECTED] = '{
    '{'{14'd2024, 4'd6, 5'd15},   '{14'd2024, 4'd6, 5'd15},   1'b1, 23'sd0},
    '{'{14'd16383, 4'd15, 5'd31}, '{14'd0, 4'd0, 5'd0},       1'b1, 23'sd4194303},
    '{'{14'd0, 4'd0, 5'd0},       '{14'd16383, 4'd15, 5'd31}, 1'b1, -23'sd4194304},
    '{'{14'd1, 4'd1, 5'd1},       '{14'd0, 4'd1, 5'd1},       1'b1, 23'sd366},
    '{'{14'd2000, 4'd3, 5'd1},    '{14'd2000, 4'd2, 5'd28},   1'b1, 23'sd2},
    '{'{14'd1900, 4'd3, 5'd1},    '{14'd1900, 4'd2, 5'd28},   1'b1, 23'sd1},
    '{'{14'd2400, 4'd2, 5'd29},   '{14'd2400, 4'd3, 5'd1},    1'b1, -23'sd1},
    '{'{14'd2100, 4'd2, 5'd29},   '{14'd2100, 4'd3, 5'd1},    1'b1, 23'sd0},
    '{'{14'd0, 4'd3, 5'd1},       '{14'd0, 4'd2, 5'd28},      1'b1, 23'sd2},
    '{'{14'd2023, 4'd0, 5'd5},    '{14'd2023, 4'd1, 5'd5},    1'b1, 23'sd0},
    '{'{14'd2023, 4'd15, 5'd5},   '{14'd2023, 4'd12, 5'd5},   1'b1, 23'sd0},
    '{'{14'd2023, 4'd2, 5'd0},    '{14'd2023, 4'd1, 5'd31},   1'b1, 23'sd0},
    '{'{14'd2023, 4'd2, 5'd31},   '{14'd2023, 4'd3, 5'd3},    1'b1, 23'sd0},
    '{'{14'd9999, 4'd12, 5'd31},  '{14'd1, 4'd1, 5'd1},       1'b0, 23'sd0},
    '{'{14'd1, 4'd1, 5'd1},       '{14'd9999, 4'd12, 5'd31},  1'b0, 23'sd0},
    '{'{14'd16383, 4'd0, 5'd0},   '{14'd16383, 4'd15, 5'd31}, 1'b0, 23'sd0},
    '{'{14'd8191, 4'd7, 5'd15},   '{14'd8192, 4'd8, 5'd16},   1'b0, 23'sd0},
    '{'{14'd11483, 4'd1, 5'd1},   '{14'd0, 4'd1, 5'd1},       1'b0, 23'sd0},
    '{'{14'd0, 4'd1, 5'd1},       '{14'd11484, 4'd1, 5'd1},   1'b0, 23'sd0},
    '{'{14'd2024, 4'd12, 5'd31},  '{14'd2025, 4'd1, 5'd1},    1'b1, -23'sd1}
  };

  calendar_day_difference i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .first_year     (first_year),
    .first_month    (first_month),
    .first_day      (first_day),
    .second_year    (second_year),
    .second_month   (second_month),
    .second_day     (second_day),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .day_difference (day_difference)
  );

  always #6 clk = ~clk;

  function automatic longint days_into_year(input int unsigned month);
    case (month)
      1:       return 0;
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      default: return 334;
    endcase
  endfunction

  // Linear day number with year zero counted as a leap year.
  function automatic longint day_count(input date_t date);
    longint      yr;
    int unsigned mon;
    bit          leap;
    longint      count;
    yr   = date.year;
    mon  = (date.month == 0) ? 1 : (date.month > 12) ? 12 : date.month;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    count = yr * 365 + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
    count = count + days_into_year(mon) + date.day;
    if (mon > 2 && leap) count = count + 1;
    return count;
  endfunction

  function automatic logic signed [cdd_pkg::OUT_W-1:0] predict_day_difference(
    input date_t a, input date_t b);
    longint diff;
    diff = day_count(a) - day_count(b);
    if (diff > DIFF_MAX) diff = DIFF_MAX;
    if (diff < DIFF_MIN) diff = DIFF_MIN;
    return diff[cdd_pkg::OUT_W-1:0];
  endfunction

  task automatic random_dates(output date_t a, output date_t b);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      a = '{$urandom_range(9999, 1), $urandom_range(12, 1), $urandom_range(28, 1)};
      b = '{$urandom_range(9999, 1), $urandom_range(12, 1), $urandom_range(28, 1)};
    end else if (pick < 75) begin
      a = '{$urandom_range(9999, 1), $urandom_range(12, 1), $urandom_range(31, 1)};
      b = '{a.year + $urandom_range(4) - 2, $urandom_range(12, 1), $urandom_range(31, 1)};
    end else if (pick < 85) begin
      a = '{100 * $urandom_range(99), $urandom_range(3, 2), $urandom_range(31, 1)};
      b = '{a.year, $urandom_range(3, 2), $urandom_range(31, 1)};
    end else begin
      a = '{$urandom, $urandom, $urandom};
      b = '{$urandom, $urandom, $urandom};
    end
  endtask

  task automatic send_dates(input date_t a, input date_t b, input logic typed,
                            input logic signed [cdd_pkg::OUT_W-1:0] typed_diff);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    first_year   <= a.year;
    first_month  <= a.month;
    first_day    <= a.day;
    second_year  <= b.year;
    second_month <= b.month;
    second_day   <= b.day;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_differences.push_back(typed ? typed_diff : predict_day_difference(a, b));
  endtask

  task automatic wait_for_results();
    while (pending_differences.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** calendar_day_difference: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_trig != hold_seen) begin
        hold_seen = hold_trig;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      if (out_valid && out_ready) begin
        if (pending_differences.size() == 0) begin
          $error("day_difference: no word expected, actual %0d", day_difference);
          mismatch_count++;
        end else begin
          expected_diff = pending_differences.pop_front();
          if (day_difference !== expected_diff) begin
            $error("day_difference: expected %0d, actual %0d", expected_diff, day_difference);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_dates(directed_rows[i].first, directed_rows[i].second, directed_rows[i].typed,
                 directed_rows[i].diff);
    end
    in_valid <= 1'b0;
    wait_for_results();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_plan[p];
      recv_stall_pct = recv_plan[p];
      repeat (PHASE_WORDS) begin
        random_dates(date_a, date_b);
        send_dates(date_a, date_b, 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_for_results();
    end

    // The receiver holds off while words keep coming, so the block backs up.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_trig <= ~hold_trig;
    repeat (PRESSURE_WORDS) begin
      random_dates(date_a, date_b);
      send_dates(date_a, date_b, 1'b0, '0);
    end
    in_valid <= 1'b0;
    wait_for_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_differences.size() != 0) begin
      $error("day_difference: %0d words never arrived", pending_differences.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** calendar_day_difference: PASSED **");
    end else begin
      $display("** calendar_day_difference: FAILED **");
    end
    $finish;
  end

endmodule
